// ===== design/aowp_pkg.sv =====
package aowp_pkg;

    typedef struct packed {
        logic        cmd;
        logic [63:0] word_w3;
        logic [63:0] word_w2;
        logic [63:0] word_w1;
        logic [63:0] word_w0;
        logic [2:0]  read_select;
    } t_in_word;

    typedef struct packed {
        logic        error;
        logic [11:0] skip_words;
        logic        order_done;
        logic [2:0]  offer_kind;
        logic [2:0]  consider_kind;
        logic [5:0]  flags;
        logic [63:0] amount_lane;
    } t_out_word;

    localparam logic [2:0] K_UNSET  = 3'd0;
    localparam logic [2:0] K_NATIVE = 3'd1;
    localparam logic [2:0] K_ERC20  = 3'd2;
    localparam logic [2:0] K_NFT    = 3'd3;
    localparam logic [2:0] K_MERC20 = 3'd4;
    localparam logic [2:0] K_MNFT   = 3'd5;

    localparam int F_ACCEPT = 0;
    localparam int F_ODUTCH = 1;
    localparam int F_CDUTCH = 2;
    localparam int F_NOCALC = 3;
    localparam int F_O0SEEN = 4;
    localparam int F_C0SEEN = 5;

    localparam logic [2:0] PARAM_DONE = 3'd6;
    localparam logic [7:0] PLAIN_OFFSET = 8'd64;
    localparam logic [7:0] ADV_OFFSET   = 8'd160;
    localparam logic [11:0] PARAM_SKIP  = 12'd9;

endpackage

// ===== design/abi_order_word_parser_unit.sv =====
// path: an accepted word passes the input register and then the result register
// throughput: one word per cycle unless the receiver stalls the result; the whole
//   parse step is one pass of logic between the input register and the result
//   register (256-bit add and compares)
// reset: synchronous active low; all parse state, flags, amounts and the mode clear
// to zero and the output register empties
module abi_order_word_parser_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  aowp_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output aowp_pkg::t_out_word  o_data
);

    logic        r_mode;
    logic [2:0]  r_ostep, r_pstep, r_istep;
    logic [15:0] r_left;
    logic [2:0]  r_okind, r_ckind;
    logic [2:0]  r_cur;
    logic [63:0] r_oaddr [3];
    logic [63:0] r_caddr [3];
    logic [255:0] r_oamt, r_camt;
    logic [5:0]  r_flags;
    logic [31:0] r_num, r_den;

    // input register
    logic        r_in_valid;
    aowp_pkg::t_in_word r_in;
    logic        r_out_valid;
    aowp_pkg::t_out_word r_out;

    logic adv;
    assign adv = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // next-state logic
    logic [2:0]  n_ostep, n_pstep, n_istep, n_okind, n_ckind, n_cur;
    logic [15:0] n_left;
    logic [63:0] n_oaddr [3];
    logic [63:0] n_caddr [3];
    logic [255:0] n_oamt, n_camt;
    logic [5:0]  n_flags;
    logic [31:0] n_num, n_den;
    logic        n_err, n_done;
    logic [11:0] n_skip;
    logic [63:0] n_lane;

    logic [63:0] w0, w1, w2, w3;
    logic [255:0] wv;
    logic [2:0] tkind;
    logic fit1, fit2, fit4, hi0;
    assign w0 = r_in.word_w0;
    assign w1 = r_in.word_w1;
    assign w2 = r_in.word_w2;
    assign w3 = r_in.word_w3;
    assign wv = {w3, w2, w1, w0};
    assign hi0 = (w3 | w2 | w1) == 64'd0;
    assign fit1 = hi0 && (w0[63:8] == 56'd0);
    assign fit2 = hi0 && (w0[63:16] == 48'd0);
    assign fit4 = hi0 && (w0[63:32] == 32'd0);

    always_comb begin
        case (w0[7:0]) inside
            8'd0:         tkind = aowp_pkg::K_NATIVE;
            8'd1:         tkind = aowp_pkg::K_ERC20;
            [8'd2:8'd5]:  tkind = aowp_pkg::K_NFT;
            default:      tkind = aowp_pkg::K_UNSET;
        endcase
    end

    // shared side unit, selects offer or consideration
    logic         consi;
    logic [2:0]   s_kind;
    logic [63:0]  s_addr [3];
    logic [255:0] s_amt;
    logic [256:0] s_sum;
    assign consi = (r_pstep == 3'd5);
    assign s_kind = consi ? r_ckind : r_okind;
    assign s_addr[0] = consi ? r_caddr[0] : r_oaddr[0];
    assign s_addr[1] = consi ? r_caddr[1] : r_oaddr[1];
    assign s_addr[2] = consi ? r_caddr[2] : r_oaddr[2];
    assign s_amt = consi ? r_camt : r_oamt;
    assign s_sum = {1'b0, s_amt} + {1'b0, wv};

    logic [2:0]   k_n;
    logic [63:0]  a_n [3];
    logic [255:0] m_n;
    logic [5:0]   f_n;
    logic [2:0]   is_n, cur_n;
    logic [15:0]  l_n;
    logic         s_err;

    always_comb begin
        k_n = s_kind;
        a_n = s_addr;
        m_n = s_amt;
        f_n = r_flags;
        is_n = r_istep;
        cur_n = r_cur;
        l_n = r_left;
        s_err = 1'b0;
        case (r_istep)
            3'd0: begin
                if (tkind == aowp_pkg::K_UNSET) begin
                    s_err = 1'b1;
                end else begin
                    if (s_kind == aowp_pkg::K_UNSET) begin
                        k_n = tkind;
                        if (!consi && (tkind == aowp_pkg::K_ERC20 ||
                                       tkind == aowp_pkg::K_NATIVE))
                            f_n[aowp_pkg::F_ACCEPT] = 1'b1;
                    end
                    cur_n = tkind;
                    is_n = 3'd1;
                end
            end
            3'd1: begin
                if (s_kind == aowp_pkg::K_NATIVE) begin
                    if (r_cur == aowp_pkg::K_ERC20) k_n = aowp_pkg::K_MERC20;
                end else if ((s_addr[0] | s_addr[1] | s_addr[2]) == 64'd0) begin
                    a_n[0] = w0;
                    a_n[1] = w1;
                    a_n[2] = {32'd0, w2[31:0]};
                end else if (r_cur == s_kind && (s_addr[0] != w0 || s_addr[1] != w1 ||
                             s_addr[2] != {32'd0, w2[31:0]})) begin
                    k_n = (s_kind == aowp_pkg::K_ERC20) ? aowp_pkg::K_MERC20
                                                        : aowp_pkg::K_MNFT;
                end
                is_n = 3'd2;
            end
            3'd2: is_n = 3'd3;
            3'd3: begin
                if (s_kind == r_cur || (s_kind == aowp_pkg::K_MNFT &&
                                        r_cur == aowp_pkg::K_NFT)) begin
                    m_n = s_sum[255:0];
                    s_err = s_sum[256];
                end
                is_n = 3'd4;
            end
            3'd4: begin
                if (!r_flags[consi ? aowp_pkg::F_C0SEEN : aowp_pkg::F_O0SEEN]) begin
                    if (s_amt != wv)
                        f_n[consi ? aowp_pkg::F_CDUTCH : aowp_pkg::F_ODUTCH] = 1'b1;
                    f_n[consi ? aowp_pkg::F_C0SEEN : aowp_pkg::F_O0SEEN] = 1'b1;
                end
                if (consi) begin
                    is_n = 3'd5;
                end else begin
                    l_n = r_left - 16'd1;
                    is_n = 3'd0;
                end
            end
            3'd5: begin
                if (!consi) begin
                    s_err = 1'b1;
                end else begin
                    l_n = r_left - 16'd1;
                    is_n = 3'd0;
                end
            end
            default: s_err = 1'b1;
        endcase
    end

    // order and parameter walk
    logic in_params;
    logic [2:0] param_next;
    logic len_step, len_done;
    logic [11:0] len_words;
    assign len_words = {1'b0, w0[15:5]} + {11'd0, (w0[4:0] != 5'd0)};

    always_comb begin
        n_ostep = r_ostep; n_pstep = r_pstep; n_istep = r_istep;
        n_okind = r_okind; n_ckind = r_ckind; n_cur = r_cur;
        n_left = r_left; n_oaddr = r_oaddr; n_caddr = r_caddr;
        n_oamt = r_oamt; n_camt = r_camt; n_flags = r_flags;
        n_num = r_num; n_den = r_den;
        n_err = 1'b0; n_done = 1'b0; n_skip = 12'd0; n_lane = 64'd0;
        in_params = 1'b0; param_next = 3'd0; len_step = 1'b0; len_done = 1'b0;
        if (r_in.cmd) begin
            case (r_in.read_select)
                3'd0: n_lane = r_oamt[63:0];
                3'd1: n_lane = r_oamt[127:64];
                3'd2: n_lane = r_oamt[191:128];
                3'd3: n_lane = r_oamt[255:192];
                3'd4: n_lane = r_camt[63:0];
                3'd5: n_lane = r_camt[127:64];
                3'd6: n_lane = r_camt[191:128];
                default: n_lane = r_camt[255:192];
            endcase
        end else if (!r_mode) begin
            case (r_ostep)
                3'd0: if (!fit1 || w0[7:0] != aowp_pkg::PLAIN_OFFSET) n_err = 1'b1;
                      else n_ostep = 3'd1;
                3'd1: n_ostep = 3'd2;
                3'd2: begin in_params = 1'b1; param_next = 3'd3; end
                3'd3: begin len_step = 1'b1; len_done = 1'b1; end
                default: n_err = 1'b1;
            endcase
        end else begin
            case (r_ostep)
                3'd0: if (!fit1 || w0[7:0] != aowp_pkg::ADV_OFFSET) n_err = 1'b1;
                      else n_ostep = 3'd1;
                3'd1: if (!fit4) n_err = 1'b1;
                      else begin n_num = w0[31:0]; n_ostep = 3'd2; end
                3'd2: if (!fit4) n_err = 1'b1;
                      else begin
                          n_den = w0[31:0];
                          if (r_num != 32'd0 && w0[31:0] != 32'd0 && r_num != w0[31:0])
                              n_flags[aowp_pkg::F_NOCALC] = 1'b1;
                          n_ostep = 3'd3;
                      end
                3'd3: n_ostep = 3'd4;
                3'd4: n_ostep = 3'd5;
                3'd5: begin in_params = 1'b1; param_next = 3'd6; end
                3'd6: len_step = 1'b1;
                default: begin len_step = 1'b1; len_done = 1'b1; end
            endcase
        end

        if (len_step) begin
            if (!fit2) begin
                n_err = 1'b1;
            end else begin
                n_left = w0[15:0];
                n_skip = len_words;
                if (len_done) begin
                    n_done = 1'b1;
                    n_ostep = 3'd0;
                end else begin
                    n_ostep = 3'd7;
                end
            end
        end

        if (in_params) begin
            case (r_pstep)
                3'd0: begin n_skip = aowp_pkg::PARAM_SKIP; n_pstep = 3'd1; end
                3'd1: begin n_pstep = 3'd2; n_istep = 3'd0; end
                3'd2: begin
                    n_left = w0[15:0];
                    if (w0[15:0] == 16'd0) n_err = 1'b1;
                    else n_pstep = 3'd3;
                end
                3'd3, 3'd5: begin
                    n_err = s_err;
                    if (!(r_istep == 3'd0 && tkind == aowp_pkg::K_UNSET)) begin
                        n_flags = f_n; n_istep = is_n; n_cur = cur_n; n_left = l_n;
                    end
                    if (consi) begin
                        n_ckind = k_n; n_caddr = a_n; n_camt = m_n;
                    end else begin
                        n_okind = k_n; n_oaddr = a_n; n_oamt = m_n;
                    end
                    if (l_n == 16'd0) begin
                        n_pstep = consi ? aowp_pkg::PARAM_DONE : 3'd4;
                        n_istep = 3'd0;
                    end
                end
                3'd4: begin
                    if (!fit2) begin
                        n_err = 1'b1;
                    end else begin
                        n_left = w0[15:0];
                        if (w0[15:0] == 16'd0) begin
                            n_ckind = aowp_pkg::K_NATIVE;
                            n_pstep = aowp_pkg::PARAM_DONE;
                        end else begin
                            n_pstep = 3'd5;
                        end
                    end
                end
                default: n_err = 1'b1;
            endcase
            if (n_pstep == aowp_pkg::PARAM_DONE) begin
                n_pstep = 3'd0;
                n_ostep = param_next;
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ostep <= 3'd0; r_pstep <= 3'd0; r_istep <= 3'd0;
            r_left <= 16'd0; r_okind <= aowp_pkg::K_UNSET; r_ckind <= aowp_pkg::K_UNSET;
            r_cur <= 3'd0; r_oaddr <= '{default: 64'd0}; r_caddr <= '{default: 64'd0};
            r_oamt <= '0; r_camt <= '0; r_flags <= 6'd0; r_num <= 32'd0; r_den <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (adv) begin
                r_ostep <= n_ostep; r_pstep <= n_pstep; r_istep <= n_istep;
                r_left <= n_left; r_okind <= n_okind; r_ckind <= n_ckind;
                r_cur <= n_cur; r_oaddr <= n_oaddr; r_caddr <= n_caddr;
                r_oamt <= n_oamt; r_camt <= n_camt; r_flags <= n_flags;
                r_num <= n_num; r_den <= n_den;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_out.error <= n_err;
            r_out.skip_words <= n_skip;
            r_out.order_done <= n_done;
            r_out.offer_kind <= n_okind;
            r_out.consider_kind <= n_ckind;
            r_out.flags <= n_flags;
            r_out.amount_lane <= n_lane;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data = r_out;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");
    // reads never report errors or order ends
    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.cmd |=> !o_data.error && !o_data.order_done && o_data.skip_words == 12'd0)
        else $error("read word reported parse status");
    // input side only stalls when the output is full and stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("spurious input stall");

endmodule

// ===== tb/abi_order_word_parser_unit_tb.sv =====
module abi_order_word_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] t_lanes [4];

    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_data;
    logic      i_valid;
    logic      o_stall;
    aowp_pkg::t_in_word  i_data;
    logic      o_valid;
    logic      i_stall;
    aowp_pkg::t_out_word o_data;

    abi_order_word_parser_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    always #4 i_clk = ~i_clk;

    // parser state mirror
    bit          adv_mode;
    logic [2:0]  ord_step, prm_step, itm_step;
    logic [15:0] left;
    logic [2:0]  okind, ckind, cur_kind;
    logic [63:0] oaddr [3];
    logic [63:0] caddr [3];
    logic [63:0] oamt [4];
    logic [63:0] camt [4];
    logic [5:0]  iflags;
    logic [31:0] ratio_num, ratio_den;
    logic [11:0] step_skip;
    bit          step_done;

    aowp_pkg::t_out_word result_q [$];
    int        words_sent, results_seen, orders_sent, mismatches;
    bit        quiet;
    int        idle_cycles;

    function automatic void clear_parser();
        ord_step = '0; prm_step = '0; itm_step = '0; left = '0;
        okind = aowp_pkg::K_UNSET; ckind = aowp_pkg::K_UNSET; cur_kind = '0;
        for (int i = 0; i < 3; i++) begin
            oaddr[i] = '0; caddr[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            oamt[i] = '0; camt[i] = '0;
        end
        iflags = '0; ratio_num = '0; ratio_den = '0; adv_mode = 1'b0;
    endfunction

    function automatic logic [2:0] kind_of(logic [7:0] b);
        if (b == 8'd0) return aowp_pkg::K_NATIVE;
        if (b == 8'd1) return aowp_pkg::K_ERC20;
        if (b >= 8'd2 && b <= 8'd5) return aowp_pkg::K_NFT;
        return aowp_pkg::K_UNSET;
    endfunction

    function automatic bit fits(t_lanes w, int nbytes);
        return ((w[3] | w[2] | w[1]) == 0) && ((w[0] >> (8 * nbytes)) == 0);
    endfunction

    // one word of an offer or consideration item
    function automatic bit side_word(bit consi, t_lanes w);
        logic [2:0]   kind, t;
        logic [63:0]  addr [3];
        logic [63:0]  amt [4];
        logic [63:0]  a2;
        logic [256:0] sum;
        bit           err;
        int           seen;
        err = 1'b0;
        kind = consi ? ckind : okind;
        for (int i = 0; i < 3; i++) addr[i] = consi ? caddr[i] : oaddr[i];
        for (int i = 0; i < 4; i++) amt[i] = consi ? camt[i] : oamt[i];
        case (itm_step)
            3'd0: begin
                t = kind_of(w[0][7:0]);
                if (t == aowp_pkg::K_UNSET) return 1'b1;
                if (kind == aowp_pkg::K_UNSET) begin
                    kind = t;
                    if (!consi && (t == aowp_pkg::K_ERC20 || t == aowp_pkg::K_NATIVE))
                        iflags[aowp_pkg::F_ACCEPT] = 1'b1;
                end
                cur_kind = t;
                itm_step = 3'd1;
            end
            3'd1: begin
                if (kind == aowp_pkg::K_NATIVE) begin
                    if (cur_kind == aowp_pkg::K_ERC20) kind = aowp_pkg::K_MERC20;
                end else begin
                    a2 = {32'd0, w[2][31:0]};
                    if ((addr[0] | addr[1] | addr[2]) == 0) begin
                        addr[0] = w[0]; addr[1] = w[1]; addr[2] = a2;
                    end else if (cur_kind == kind &&
                                 (addr[0] != w[0] || addr[1] != w[1] || addr[2] != a2)) begin
                        kind = (kind == aowp_pkg::K_ERC20) ? aowp_pkg::K_MERC20
                                                           : aowp_pkg::K_MNFT;
                    end
                end
                itm_step = 3'd2;
            end
            3'd2: itm_step = 3'd3;
            3'd3: begin
                if (kind == cur_kind ||
                    (kind == aowp_pkg::K_MNFT && cur_kind == aowp_pkg::K_NFT)) begin
                    sum = {1'b0, amt[3], amt[2], amt[1], amt[0]} +
                          {1'b0, w[3], w[2], w[1], w[0]};
                    {amt[3], amt[2], amt[1], amt[0]} = sum[255:0];
                    err = sum[256];
                end
                itm_step = 3'd4;
            end
            3'd4: begin
                seen = consi ? aowp_pkg::F_C0SEEN : aowp_pkg::F_O0SEEN;
                if (!iflags[seen]) begin
                    if (amt[0] != w[0] || amt[1] != w[1] || amt[2] != w[2] || amt[3] != w[3])
                        iflags[consi ? aowp_pkg::F_CDUTCH : aowp_pkg::F_ODUTCH] = 1'b1;
                    iflags[seen] = 1'b1;
                end
                if (consi) begin
                    itm_step = 3'd5;
                end else begin
                    left = left - 16'd1;
                    itm_step = 3'd0;
                end
            end
            3'd5: begin
                if (!consi) return 1'b1;
                left = left - 16'd1;
                itm_step = 3'd0;
            end
            default: return 1'b1;
        endcase
        if (consi) begin
            ckind = kind; caddr = addr; camt = amt;
        end else begin
            okind = kind; oaddr = addr; oamt = amt;
        end
        return err;
    endfunction

    function automatic bit param_word(t_lanes w);
        bit err;
        err = 1'b0;
        case (prm_step)
            3'd0: begin
                step_skip = aowp_pkg::PARAM_SKIP;
                prm_step = 3'd1;
            end
            3'd1: begin
                prm_step = 3'd2;
                itm_step = 3'd0;
            end
            3'd2: begin
                left = w[0][15:0];
                if (left == 0) return 1'b1;
                prm_step = 3'd3;
            end
            3'd3: begin
                err = side_word(1'b0, w);
                if (left == 0) begin
                    prm_step = 3'd4; itm_step = 3'd0;
                end
            end
            3'd4: begin
                if (!fits(w, 2)) return 1'b1;
                left = w[0][15:0];
                if (left == 0) begin
                    ckind = aowp_pkg::K_NATIVE;
                    prm_step = aowp_pkg::PARAM_DONE;
                end else begin
                    prm_step = 3'd5;
                end
            end
            3'd5: begin
                err = side_word(1'b1, w);
                if (left == 0) begin
                    prm_step = aowp_pkg::PARAM_DONE; itm_step = 3'd0;
                end
            end
            default: return 1'b1;
        endcase
        return err;
    endfunction

    function automatic bit params_then(t_lanes w, logic [2:0] nxt);
        bit err;
        err = param_word(w);
        if (prm_step == aowp_pkg::PARAM_DONE) begin
            prm_step = 3'd0;
            ord_step = nxt;
        end
        return err;
    endfunction

    // signature or extradata length word; 0 when malformed
    function automatic bit length_word(t_lanes w);
        if (!fits(w, 2)) return 1'b0;
        left = w[0][15:0];
        step_skip = 12'(left / 32 + ((left % 32) != 0 ? 1 : 0));
        return 1'b1;
    endfunction

    function automatic bit plain_word(t_lanes w);
        case (ord_step)
            3'd0: begin
                if (!fits(w, 1) || w[0][7:0] != aowp_pkg::PLAIN_OFFSET) return 1'b1;
                ord_step = 3'd1;
            end
            3'd1: ord_step = 3'd2;
            3'd2: return params_then(w, 3'd3);
            3'd3: begin
                if (!length_word(w)) return 1'b1;
                step_done = 1'b1;
                ord_step = 3'd0;
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    function automatic bit advanced_word(t_lanes w);
        case (ord_step)
            3'd0: begin
                if (!fits(w, 1) || w[0][7:0] != aowp_pkg::ADV_OFFSET) return 1'b1;
                ord_step = 3'd1;
            end
            3'd1: begin
                if (!fits(w, 4)) return 1'b1;
                ratio_num = w[0][31:0];
                ord_step = 3'd2;
            end
            3'd2: begin
                if (!fits(w, 4)) return 1'b1;
                ratio_den = w[0][31:0];
                if (ratio_num != 0 && ratio_den != 0 && ratio_num != ratio_den)
                    iflags[aowp_pkg::F_NOCALC] = 1'b1;
                ord_step = 3'd3;
            end
            3'd3: ord_step = 3'd4;
            3'd4: ord_step = 3'd5;
            3'd5: return params_then(w, 3'd6);
            3'd6: begin
                if (!length_word(w)) return 1'b1;
                ord_step = 3'd7;
            end
            default: begin
                if (!length_word(w)) return 1'b1;
                step_done = 1'b1;
                ord_step = 3'd0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic aowp_pkg::t_out_word parse_result(aowp_pkg::t_in_word d);
        aowp_pkg::t_out_word r;
        t_lanes    w;
        bit        err;
        w[3] = d.word_w3; w[2] = d.word_w2; w[1] = d.word_w1; w[0] = d.word_w0;
        step_skip = '0; step_done = 1'b0; err = 1'b0;
        r = '0;
        if (d.cmd) begin
            r.amount_lane = (d.read_select < 4) ? oamt[d.read_select[1:0]]
                                                : camt[d.read_select[1:0]];
        end else if (adv_mode) begin
            err = advanced_word(w);
        end else begin
            err = plain_word(w);
        end
        r.error = err;
        r.skip_words = step_skip;
        r.order_done = step_done;
        r.offer_kind = okind;
        r.consider_kind = ckind;
        r.flags = iflags;
        return r;
    endfunction

    // one word to the block, predicted on acceptance
    task automatic send_word(bit cmd, t_lanes w, logic [2:0] sel);
        aowp_pkg::t_in_word d;
        d.cmd = cmd; d.read_select = sel;
        d.word_w3 = w[3]; d.word_w2 = w[2]; d.word_w1 = w[1]; d.word_w0 = w[0];
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        result_q.push_back(parse_result(d));
        words_sent++;
    endtask

    task automatic parse(t_lanes w);
        send_word(1'b0, w, 3'($urandom_range(0, 7)));
    endtask

    task automatic parse_value(logic [63:0] v);
        t_lanes w;
        w[3] = '0; w[2] = '0; w[1] = '0; w[0] = v;
        parse(w);
    endtask

    task automatic read_lane(logic [2:0] sel);
        t_lanes w;
        for (int i = 0; i < 4; i++) w[i] = {$urandom, $urandom};
        send_word(1'b1, w, sel);
    endtask

    function automatic t_lanes noise_lanes();
        t_lanes w;
        for (int i = 0; i < 4; i++) w[i] = {$urandom, $urandom};
        return w;
    endfunction

    // mode writes only with the block drained
    task automatic set_mode(bit m);
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        adv_mode = m;
    endtask

    function automatic t_lanes token_lanes(int idx);
        t_lanes w;
        w = noise_lanes();
        case (idx)
            0: begin w[0] = '0; w[1] = '0; w[2][31:0] = '0; end
            1: begin w[0] = 64'h1111; w[1] = '0; w[2][31:0] = 32'h1; end
            2: begin w[0] = 64'h2222; w[1] = 64'h5; w[2][31:0] = 32'h1; end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_lanes amount_lanes();
        t_lanes w;
        w = noise_lanes();
        case ($urandom_range(0, 3))
            0: begin
                w[3] = '0; w[2] = '0; w[1] = '0; w[0] = 64'($urandom_range(0, 1000));
            end
            1: begin w[3] = '1; w[2] = '1; w[1] = '1; w[0] = '1; end
            2: w[3] = {32'd0, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] item_type();
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[7:0] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(6, 255))
                                              : 8'($urandom_range(0, 5));
        return v;
    endfunction

    // one offer or consideration item with random content
    task automatic send_item(bit consi);
        t_lanes amt;
        t_lanes w;
        w = noise_lanes();
        w[0] = item_type();
        parse(w);
        parse(token_lanes($urandom_range(0, 3)));
        parse(noise_lanes());
        amt = amount_lanes();
        parse(amt);
        if ($urandom_range(0, 1) == 1) parse(amt);
        else parse(amount_lanes());
        if (consi) parse(noise_lanes());
    endtask

    function automatic logic [63:0] length_value();
        return ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 16'hffff));
    endfunction

    // well-formed order in the current mode, optionally with a broken field
    task automatic send_order(int n_offer, int n_consi);
        if (adv_mode) begin
            parse_value(64'(aowp_pkg::ADV_OFFSET));
            parse_value($urandom_range(0, 3) == 0 ? 64'd1 : 64'($urandom_range(0, 4)));
            parse_value($urandom_range(0, 3) == 0 ? 64'd1 : 64'($urandom_range(0, 4)));
            parse(noise_lanes());
            parse(noise_lanes());
        end else begin
            parse_value(64'(aowp_pkg::PLAIN_OFFSET));
            parse(noise_lanes());
        end
        parse(noise_lanes());
        parse(noise_lanes());
        parse_value(64'(n_offer));
        for (int i = 0; i < n_offer; i++) send_item(1'b0);
        parse_value(64'(n_consi));
        for (int i = 0; i < n_consi; i++) send_item(1'b1);
        parse_value(length_value());
        if (adv_mode) parse_value(length_value());
        if ($urandom_range(0, 3) == 0) read_lane(3'($urandom_range(0, 7)));
        orders_sent++;
    endtask

    task automatic test_directed_plain();
        t_lanes w;
        for (int s = 0; s < 8; s++) read_lane(3'(s));
        parse_value(64'd65);          // bad offset
        w = noise_lanes();
        parse(w);                      // fully random word as offset
        send_order(1, 0);              // zero consideration count
        parse_value(64'(aowp_pkg::PLAIN_OFFSET));
        parse(noise_lanes());
        parse(noise_lanes());
        parse(noise_lanes());
        parse_value(64'd0);            // zero offer count
        parse_value(64'd1);
        w = noise_lanes();
        w[0][7:0] = 8'd200;            // unknown item type
        parse(w);
    endtask

    task automatic test_directed_advanced();
        parse_value(64'(aowp_pkg::ADV_OFFSET));
        parse_value(64'h1_0000_0000);  // ratio too wide
        parse_value(64'd2);
        parse_value(64'd3);            // ratio other than one
        parse(noise_lanes());
        parse(noise_lanes());
        parse(noise_lanes());
        parse(noise_lanes());
        parse_value(64'd1);
        send_item(1'b0);
        parse_value(64'd1 << 16);      // consideration count too wide
        parse_value(64'd1);
        send_item(1'b1);
        parse_value(64'd33);
        parse_value(64'd1 << 20);      // extradata length too wide
        parse_value(64'd32);
    endtask

    task automatic test_random_orders(int target);
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0: parse(noise_lanes());
                1: read_lane(3'($urandom_range(0, 7)));
                default: send_order($urandom_range(1, 3), $urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic test_mode_sweep();
        for (int i = 0; i < 6; i++) begin
            set_mode(1'(i % 2));
            test_random_orders(words_sent + 120);
        end
    endtask

    // result checking
    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        aowp_pkg::t_out_word e;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (result_q.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                e = result_q.pop_front();
                check_field("error", 64'(e.error), 64'(o_data.error));
                check_field("skip_words", 64'(e.skip_words), 64'(o_data.skip_words));
                check_field("order_done", 64'(e.order_done), 64'(o_data.order_done));
                check_field("offer_kind", 64'(e.offer_kind), 64'(o_data.offer_kind));
                check_field("consider_kind", 64'(e.consider_kind),
                            64'(o_data.consider_kind));
                check_field("flags", 64'(e.flags), 64'(o_data.flags));
                check_field("amount_lane", e.amount_lane, o_data.amount_lane);
            end
        end
    end

    // receiver stall bursts
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) i_stall <= 1'b1;
            else i_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int waited;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_plain();
        set_mode(1'b1);
        test_directed_advanced();
        set_mode(1'b0);
        test_random_orders(words_sent + 600);
        set_mode(1'b1);
        test_random_orders(words_sent + 400);
        test_mode_sweep();
        quiet = 1'b1;
        set_mode(1'b0);
        test_random_orders(words_sent + 100);

        i_valid <= 1'b0;
        waited = 0;
        while (result_q.size() != 0 && waited < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        $display("covered %0d words in %0d orders, plain and advanced modes, %0d results",
                 words_sent, orders_sent, results_seen);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
